FILE: rtl/psa_pkg.sv
// psa_pkg: shared codes for the page span allocator
`timescale 1ns / 1ps
package psa_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int PAGE_W   = 40;
  localparam int COUNT_W  = 11;

  // request codes
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_FREE  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_REQ   = 3'd4;

  // span state codes
  localparam logic [1:0] SPAN_DEAD  = 2'd0;
  localparam logic [1:0] SPAN_FREE  = 2'd1;
  localparam logic [1:0] SPAN_HEAP  = 2'd2;
  localparam logic [1:0] SPAN_STACK = 2'd3;

endpackage

FILE: rtl/page_span_allocator_top.sv
// page_span_allocator_top: span allocator over a page arena, memory based sequencer
`timescale 1ns / 1ps
//
//  channel   signals                                   direction
//  -------   ----------------------------------------  ---------
//  in        in_valid_i / in_ready_o, operation_i,     request in
//            page_count_i, is_stack_i, page_number_i
//  out       out_valid_o / out_ready_i, status_o,      result out
//            span_start_o, span_pages_o
//  cfg       cfg_valid_i / cfg_ready_o,                register write
//            arena_base_page_i
//
//  one request at a time; the sequencer walks the span memories through a
//  single read port and a single write port per memory (registered read)
//  lookup reads the page owner, then its span; free merges with free neighbours (each
//  merge is a list unlink); allocate scans the exact size lists upward, then walks the
//  large list for a best fit, then unlinks, splits, frees the tail and owns each page
//  after reset a clearing pass over every entry of the span memories runs
//  before the first request is taken; cfg writes are taken at any time
//  a finished result waits in the output register while the next request runs
module page_span_allocator_top #(
  parameter int NUM_PAGES   = 1024,
  parameter int SMALL_LISTS = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [psa_pkg::OP_W-1:0]       operation_i,
  input  logic [psa_pkg::COUNT_W-1:0]    page_count_i,
  input  logic                           is_stack_i,
  input  logic [psa_pkg::PAGE_W-1:0]     page_number_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [psa_pkg::STATUS_W-1:0]   status_o,
  output logic [psa_pkg::PAGE_W-1:0]     span_start_o,
  output logic [psa_pkg::COUNT_W-1:0]    span_pages_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [psa_pkg::PAGE_W-1:0]     arena_base_page_i
);
  import psa_pkg::*;

  localparam int PW   = $clog2(NUM_PAGES);        // page index
  localparam int IW   = $clog2(NUM_PAGES + 1);    // span id incl. null
  localparam int LW   = IW;                       // span length
  localparam int HW   = $clog2(SMALL_LISTS + 1);  // list index
  localparam int CW   = (LW > COUNT_W) ? LW : COUNT_W;
  localparam int CLRN = (NUM_PAGES > SMALL_LISTS + 1) ? NUM_PAGES : SMALL_LISTS + 1;
  localparam int KW   = $clog2(CLRN);
  localparam logic [IW-1:0] NIL = IW'(NUM_PAGES);

  typedef enum logic [28:0] {
    ST_CLR    = 29'd1 << 0,
    ST_IDLE   = 29'd1 << 1,
    ST_DISP   = 29'd1 << 2,
    ST_SCAN   = 29'd1 << 3,
    ST_LHEAD  = 29'd1 << 4,
    ST_LEVAL  = 29'd1 << 5,
    ST_RM_RD  = 29'd1 << 6,
    ST_RM_W1  = 29'd1 << 7,
    ST_RM_W2  = 29'd1 << 8,
    ST_SPLIT  = 29'd1 << 9,
    ST_SP2    = 29'd1 << 10,
    ST_MARK   = 29'd1 << 11,
    ST_FILL   = 29'd1 << 12,
    ST_FCHK   = 29'd1 << 13,
    ST_LK1    = 29'd1 << 14,
    ST_LK2    = 29'd1 << 15,
    ST_REL0   = 29'd1 << 16,
    ST_RELP1  = 29'd1 << 17,
    ST_RELP2  = 29'd1 << 18,
    ST_RELP3  = 29'd1 << 19,
    ST_RELN0  = 29'd1 << 20,
    ST_RELN1  = 29'd1 << 21,
    ST_RELN2  = 29'd1 << 22,
    ST_RELN3  = 29'd1 << 23,
    ST_FIN1   = 29'd1 << 24,
    ST_FIN2   = 29'd1 << 25,
    ST_PU_W1  = 29'd1 << 26,
    ST_PU_W2  = 29'd1 << 27,
    ST_RESULT = 29'd1 << 28
  } state_e;

  // exact size list for short spans, large list otherwise
  function automatic logic [HW-1:0] list_of(input logic [LW-1:0] l);
    if (32'(l) < 32'(SMALL_LISTS)) begin
      list_of = HW'(l);
    end else begin
      list_of = HW'(SMALL_LISTS);
    end
  endfunction

  // control state
  state_e state_q, state_d, rm_ret_q, rm_ret_d, rel_ret_q, rel_ret_d;
  logic [KW-1:0] clr_q, clr_d;
  logic          out_valid_q, out_valid_d;
  logic [PAGE_W-1:0] base_q;

  // request and working registers
  logic [OP_W-1:0]    op_q;
  logic [COUNT_W-1:0] npage_q;
  logic               stack_q;
  logic [PAGE_W-1:0]  page_q;
  logic [IW-1:0] s_q, s_d, i_q, i_d, best_q, best_d, rs_q, rs_d, t_q, t_d;
  logic [IW-1:0] rm_x_q, rm_x_d, pu_h_q, pu_h_d;
  logic [LW-1:0] best_len_q, best_len_d, rlen_q, rlen_d, rm_len_q, rm_len_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [HW-1:0] n_q, n_d;
  logic          rprev_q, rprev_d;
  logic [STATUS_W-1:0] rstat_q, rstat_d, status_q, status_d;
  logic [PAGE_W-1:0]   rstart_q, rstart_d, start_q, start_d;
  logic [COUNT_W-1:0]  rpages_q, rpages_d, pages_q, pages_d;

  // memory ports
  logic          own_we, len_we, stat_we, nxt_we, prv_we, head_we;
  logic [PW-1:0] own_wa, own_ra, len_wa, len_ra, stat_wa, stat_ra;
  logic [PW-1:0] nxt_wa, nxt_ra, prv_wa, prv_ra;
  logic [HW-1:0] head_wa, head_ra;
  logic [IW-1:0] own_wd, own_rd, nxt_wd, nxt_rd, prv_wd, prv_rd, head_wd, head_rd;
  logic [LW-1:0] len_wd, len_rd;
  logic [1:0]    stat_wd, stat_rd;

  // derived values
  logic [PAGE_W:0]   diff;
  logic              in_arena;
  logic [PW-1:0]     off;
  logic [CW-1:0]     npx;
  logic [CW-1:0]     split_t;
  logic [CW-1:0]     split_len;
  logic [IW:0]       nb_end;
  logic [IW:0]       rel_q;
  logic [IW:0]       lk_end;
  logic              walk_hit;
  logic [IW-1:0]     walk_best;
  logic              accept;

  assign diff      = {1'b0, page_q} - {1'b0, base_q};
  assign in_arena  = !diff[PAGE_W] && (diff[PAGE_W-1:0] < PAGE_W'(NUM_PAGES));
  assign off       = diff[PW-1:0];
  assign npx       = CW'(npage_q);
  assign split_t   = CW'(s_q) + npx;
  assign split_len = CW'(rm_len_q) - npx;
  assign nb_end    = {1'b0, t_q} + {1'b0, len_rd};
  assign rel_q     = {1'b0, rs_q} + {1'b0, rlen_q};
  assign lk_end    = {1'b0, s_q} + {1'b0, len_rd};
  assign walk_hit  = (CW'(len_rd) >= npx) &&
                     ((best_q == NIL) || (len_rd < best_len_q) ||
                      ((len_rd == best_len_q) && (i_q < best_q)));
  assign walk_best = walk_hit ? i_q : best_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    rm_ret_d    = rm_ret_q;
    rel_ret_d   = rel_ret_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    s_d = s_q; i_d = i_q; best_d = best_q; best_len_d = best_len_q;
    rs_d = rs_q; rlen_d = rlen_q; rprev_d = rprev_q; t_d = t_q;
    rm_x_d = rm_x_q; rm_len_d = rm_len_q; pu_h_d = pu_h_q;
    fill_d = fill_q; n_d = n_q;
    rstat_d = rstat_q; rstart_d = rstart_q; rpages_d = rpages_q;
    status_d = status_q; start_d = start_q; pages_d = pages_q;

    own_we = 1'b0;  own_wa = '0;  own_wd = '0;  own_ra = '0;
    len_we = 1'b0;  len_wa = '0;  len_wd = '0;  len_ra = '0;
    stat_we = 1'b0; stat_wa = '0; stat_wd = '0; stat_ra = '0;
    nxt_we = 1'b0;  nxt_wa = '0;  nxt_wd = '0;  nxt_ra = '0;
    prv_we = 1'b0;  prv_wa = '0;  prv_wd = '0;  prv_ra = '0;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLR: begin
        // one entry per cycle of each memory not yet cleared
        if (32'(clr_q) < 32'(NUM_PAGES)) begin
          own_we = 1'b1; own_wa = clr_q[PW-1:0]; own_wd = '0;
          len_we = 1'b1; len_wa = clr_q[PW-1:0];
          len_wd = (clr_q == '0) ? LW'(NUM_PAGES) : '0;
          stat_we = 1'b1; stat_wa = clr_q[PW-1:0];
          stat_wd = (clr_q == '0) ? SPAN_FREE : SPAN_DEAD;
          nxt_we = 1'b1; nxt_wa = clr_q[PW-1:0]; nxt_wd = NIL;
          prv_we = 1'b1; prv_wa = clr_q[PW-1:0]; prv_wd = NIL;
        end
        if (32'(clr_q) < 32'(SMALL_LISTS + 1)) begin
          head_we = 1'b1; head_wa = clr_q[HW-1:0];
          head_wd = (32'(clr_q) == 32'(SMALL_LISTS)) ? '0 : NIL;
        end
        clr_d = clr_q + KW'(1);
        if (32'(clr_q) == 32'(CLRN - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        rstat_d = STAT_OK; rstart_d = '0; rpages_d = '0;
        best_d  = NIL;
        case (op_q)
          OP_ALLOC: begin
            if (npage_q == '0) begin
              rstat_d = STAT_BAD_REQ;
              state_d = ST_RESULT;
            end else if (32'(npage_q) < 32'(SMALL_LISTS)) begin
              n_d = HW'(npage_q);
              head_ra = HW'(npage_q);
              state_d = ST_SCAN;
            end else begin
              head_ra = HW'(SMALL_LISTS);
              state_d = ST_LHEAD;
            end
          end
          OP_FREE: begin
            if (!in_arena) begin
              rstat_d = STAT_BAD_FREE;
              state_d = ST_RESULT;
            end else begin
              stat_ra = off; len_ra = off;
              state_d = ST_FCHK;
            end
          end
          OP_LOOKUP: begin
            if (!in_arena) begin
              rstat_d = STAT_NOT_FOUND;
              state_d = ST_RESULT;
            end else begin
              own_ra = off;
              state_d = ST_LK1;
            end
          end
          default: begin
            rstat_d = STAT_BAD_REQ;
            state_d = ST_RESULT;
          end
        endcase
      end
      ST_SCAN: begin
        if (head_rd != NIL) begin
          s_d = head_rd; rm_x_d = head_rd; rm_ret_d = ST_SPLIT;
          state_d = ST_RM_RD;
        end else if (32'(n_q) == 32'(SMALL_LISTS - 1)) begin
          head_ra = HW'(SMALL_LISTS);
          state_d = ST_LHEAD;
        end else begin
          n_d = n_q + HW'(1);
          head_ra = n_q + HW'(1);
        end
      end
      ST_LHEAD: begin
        if (head_rd == NIL) begin
          rstat_d = STAT_NO_SPACE;
          state_d = ST_RESULT;
        end else begin
          i_d = head_rd;
          len_ra = head_rd[PW-1:0]; nxt_ra = head_rd[PW-1:0];
          state_d = ST_LEVAL;
        end
      end
      ST_LEVAL: begin
        // best fit walk, one node per cycle
        if (walk_hit) begin
          best_d = i_q; best_len_d = len_rd;
        end
        if (nxt_rd != NIL) begin
          i_d = nxt_rd;
          len_ra = nxt_rd[PW-1:0]; nxt_ra = nxt_rd[PW-1:0];
        end else if (walk_best == NIL) begin
          rstat_d = STAT_NO_SPACE;
          state_d = ST_RESULT;
        end else begin
          s_d = walk_best; rm_x_d = walk_best; rm_ret_d = ST_SPLIT;
          state_d = ST_RM_RD;
        end
      end
      ST_RM_RD: begin
        len_ra = rm_x_q[PW-1:0]; prv_ra = rm_x_q[PW-1:0]; nxt_ra = rm_x_q[PW-1:0];
        state_d = ST_RM_W1;
      end
      ST_RM_W1: begin
        rm_len_d = len_rd;
        if (prv_rd != NIL) begin
          nxt_we = 1'b1; nxt_wa = prv_rd[PW-1:0]; nxt_wd = nxt_rd;
        end else begin
          head_we = 1'b1; head_wa = list_of(len_rd); head_wd = nxt_rd;
        end
        if (nxt_rd != NIL) begin
          prv_we = 1'b1; prv_wa = nxt_rd[PW-1:0]; prv_wd = prv_rd;
        end
        state_d = ST_RM_W2;
      end
      ST_RM_W2: begin
        nxt_we = 1'b1; nxt_wa = rm_x_q[PW-1:0]; nxt_wd = NIL;
        prv_we = 1'b1; prv_wa = rm_x_q[PW-1:0]; prv_wd = NIL;
        state_d = rm_ret_q;
      end
      ST_SPLIT: begin
        if (CW'(rm_len_q) > npx) begin
          // tail becomes its own span, freed without a backward merge
          len_we = 1'b1; len_wa = split_t[PW-1:0]; len_wd = split_len[LW-1:0];
          own_we = 1'b1; own_wa = split_t[PW-1:0]; own_wd = split_t[IW-1:0];
          stat_we = 1'b1; stat_wa = s_q[PW-1:0]; stat_wd = SPAN_STACK;
          rs_d = split_t[IW-1:0]; rlen_d = split_len[LW-1:0];
          rprev_d = 1'b0; rel_ret_d = ST_MARK;
          state_d = ST_SP2;
        end else begin
          state_d = ST_MARK;
        end
      end
      ST_SP2: begin
        len_we = 1'b1; len_wa = s_q[PW-1:0]; len_wd = LW'(npage_q);
        own_we = 1'b1; own_wa = PW'(rs_q + rlen_q - IW'(1)); own_wd = rs_q;
        state_d = ST_REL0;
      end
      ST_REL0: begin
        stat_we = 1'b1; stat_wa = rs_q[PW-1:0]; stat_wd = SPAN_FREE;
        if (rprev_q && (rs_q != '0)) begin
          own_ra = PW'(rs_q - IW'(1));
          state_d = ST_RELP1;
        end else begin
          state_d = ST_RELN0;
        end
      end
      ST_RELP1: begin
        t_d = own_rd;
        if (own_rd < NIL) begin
          stat_ra = own_rd[PW-1:0]; len_ra = own_rd[PW-1:0];
          state_d = ST_RELP2;
        end else begin
          state_d = ST_RELN0;
        end
      end
      ST_RELP2: begin
        if ((stat_rd == SPAN_FREE) && (nb_end == {1'b0, rs_q})) begin
          rm_x_d = t_q; rm_ret_d = ST_RELP3;
          state_d = ST_RM_RD;
        end else begin
          state_d = ST_RELN0;
        end
      end
      ST_RELP3: begin
        stat_we = 1'b1; stat_wa = rs_q[PW-1:0]; stat_wd = SPAN_DEAD;
        rlen_d = rlen_q + rm_len_q;
        rs_d = t_q;
        state_d = ST_RELN0;
      end
      ST_RELN0: begin
        if (rel_q < {1'b0, NIL}) begin
          own_ra = rel_q[PW-1:0];
          state_d = ST_RELN1;
        end else begin
          state_d = ST_FIN1;
        end
      end
      ST_RELN1: begin
        if ({1'b0, own_rd} == rel_q) begin
          t_d = own_rd;
          stat_ra = own_rd[PW-1:0]; len_ra = own_rd[PW-1:0];
          state_d = ST_RELN2;
        end else begin
          state_d = ST_FIN1;
        end
      end
      ST_RELN2: begin
        if (stat_rd == SPAN_FREE) begin
          rm_x_d = t_q; rm_ret_d = ST_RELN3;
          state_d = ST_RM_RD;
        end else begin
          state_d = ST_FIN1;
        end
      end
      ST_RELN3: begin
        stat_we = 1'b1; stat_wa = t_q[PW-1:0]; stat_wd = SPAN_DEAD;
        rlen_d = rlen_q + rm_len_q;
        state_d = ST_FIN1;
      end
      ST_FIN1: begin
        stat_we = 1'b1; stat_wa = rs_q[PW-1:0]; stat_wd = SPAN_FREE;
        len_we = 1'b1; len_wa = rs_q[PW-1:0]; len_wd = rlen_q;
        own_we = 1'b1; own_wa = rs_q[PW-1:0]; own_wd = rs_q;
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        own_we = 1'b1; own_wa = PW'(rs_q + rlen_q - IW'(1)); own_wd = rs_q;
        head_ra = list_of(rlen_q);
        state_d = ST_PU_W1;
      end
      ST_PU_W1: begin
        pu_h_d = head_rd;
        prv_we = 1'b1; prv_wa = rs_q[PW-1:0]; prv_wd = NIL;
        nxt_we = 1'b1; nxt_wa = rs_q[PW-1:0]; nxt_wd = head_rd;
        head_we = 1'b1; head_wa = list_of(rlen_q); head_wd = rs_q;
        state_d = ST_PU_W2;
      end
      ST_PU_W2: begin
        if (pu_h_q != NIL) begin
          prv_we = 1'b1; prv_wa = pu_h_q[PW-1:0]; prv_wd = rs_q;
        end
        state_d = rel_ret_q;
      end
      ST_MARK: begin
        stat_we = 1'b1; stat_wa = s_q[PW-1:0];
        stat_wd = stack_q ? SPAN_STACK : SPAN_HEAP;
        fill_d = '0;
        state_d = ST_FILL;
      end
      ST_FILL: begin
        // owner of every page of the new span, one per cycle
        own_we = 1'b1; own_wa = PW'(s_q + fill_q); own_wd = s_q;
        fill_d = fill_q + LW'(1);
        if ((CW'(fill_q) + CW'(1)) == npx) begin
          rstat_d = STAT_OK;
          rstart_d = base_q + PAGE_W'(s_q);
          rpages_d = npage_q;
          state_d = ST_RESULT;
        end
      end
      ST_FCHK: begin
        if ((stat_rd != SPAN_HEAP) && (stat_rd != SPAN_STACK)) begin
          rstat_d = STAT_BAD_FREE;
          state_d = ST_RESULT;
        end else begin
          rstat_d = STAT_OK; rstart_d = page_q; rpages_d = COUNT_W'(len_rd);
          rs_d = IW'(off); rlen_d = len_rd; rprev_d = 1'b1; rel_ret_d = ST_RESULT;
          state_d = ST_REL0;
        end
      end
      ST_LK1: begin
        if (own_rd >= NIL) begin
          rstat_d = STAT_NOT_FOUND;
          state_d = ST_RESULT;
        end else begin
          s_d = own_rd;
          stat_ra = own_rd[PW-1:0]; len_ra = own_rd[PW-1:0];
          state_d = ST_LK2;
        end
      end
      ST_LK2: begin
        if ((stat_rd == SPAN_HEAP) && (IW'(off) >= s_q) && (lk_end > {1'b0, IW'(off)})) begin
          rstat_d = STAT_OK;
          rstart_d = base_q + PAGE_W'(s_q);
          rpages_d = COUNT_W'(len_rd);
        end else begin
          rstat_d = STAT_NOT_FOUND;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d = rstat_q;
          start_d  = (rstat_q == STAT_OK) ? rstart_q : '0;
          pages_d  = (rstat_q == STAT_OK) ? rpages_q : '0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      rm_ret_q    <= ST_IDLE;
      rel_ret_q   <= ST_IDLE;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      rm_ret_q    <= rm_ret_d;
      rel_ret_q   <= rel_ret_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= arena_base_page_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      npage_q <= page_count_i;
      stack_q <= is_stack_i;
      page_q  <= page_number_i;
    end
    s_q <= s_d; i_q <= i_d; best_q <= best_d; best_len_q <= best_len_d;
    rs_q <= rs_d; rlen_q <= rlen_d; rprev_q <= rprev_d; t_q <= t_d;
    rm_x_q <= rm_x_d; rm_len_q <= rm_len_d; pu_h_q <= pu_h_d;
    fill_q <= fill_d; n_q <= n_d;
    rstat_q <= rstat_d; rstart_q <= rstart_d; rpages_q <= rpages_d;
    status_q <= status_d; start_q <= start_d; pages_q <= pages_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign span_start_o = start_q;
  assign span_pages_o = pages_q;

  // span memories
  psa_ram #(.DEPTH(NUM_PAGES), .DW(IW)) u_own (
    .clk_i, .we_i(own_we), .waddr_i(own_wa), .wdata_i(own_wd),
    .raddr_i(own_ra), .rdata_o(own_rd));
  psa_ram #(.DEPTH(NUM_PAGES), .DW(LW)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_wa), .wdata_i(len_wd),
    .raddr_i(len_ra), .rdata_o(len_rd));
  psa_ram #(.DEPTH(NUM_PAGES), .DW(2)) u_stat (
    .clk_i, .we_i(stat_we), .waddr_i(stat_wa), .wdata_i(stat_wd),
    .raddr_i(stat_ra), .rdata_o(stat_rd));
  psa_ram #(.DEPTH(NUM_PAGES), .DW(IW)) u_nxt (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .raddr_i(nxt_ra), .rdata_o(nxt_rd));
  psa_ram #(.DEPTH(NUM_PAGES), .DW(IW)) u_prv (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .raddr_i(prv_ra), .rdata_o(prv_rd));
  psa_ram #(.DEPTH(SMALL_LISTS + 1), .DW(IW)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd));

endmodule

FILE: rtl/psa_ram.sv
// psa_ram: single write port, single registered read port memory
`timescale 1ns / 1ps
module psa_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/psa_checker.sv
// psa_checker: port level assertions for the page span allocator
`timescale 1ns / 1ps
module psa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [psa_pkg::STATUS_W-1:0] status_o,
  input logic [psa_pkg::PAGE_W-1:0]   span_start_o,
  input logic [psa_pkg::COUNT_W-1:0]  span_pages_o
);
  import psa_pkg::*;

  // error results carry no span
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> (span_start_o == '0 && span_pages_o == '0))
    else $error("error result with nonzero span");

  // ok results always name a span
  a_ok_pages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_OK)) |-> (span_pages_o != '0))
    else $error("ok result with zero pages");

  // one request in flight
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while busy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(span_start_o) && $stable(span_pages_o)))
    else $error("stalled result changed");

endmodule

bind page_span_allocator_top psa_checker u_psa_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .span_start_o, .span_pages_o);
